FILE: rtl/core/lru_key_value_cache_defines.svh
// Assertion helpers for the LRU cache; clk and arst_n come from the using module.
`ifndef LRU_KEY_VALUE_CACHE_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_DEFINES_SVH

// Same-cycle implication, muted while in reset
`define LKVC_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lkvc: check failed");

// Next-cycle implication, muted while in reset
`define LKVC_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lkvc: check failed");

`endif

FILE: rtl/core/lkvc_pkg.sv
package lkvc_pkg;

	localparam int unsigned DATA_W = 32;

	// Result of a get on a missing key
	localparam logic [DATA_W-1:0] MISS_VALUE = '1;
	// Result of any put
	localparam logic [DATA_W-1:0] PUT_VALUE = '0;

	typedef enum logic {
		OP_GET = 1'b0,
		OP_PUT = 1'b1
	} op_t;

	// One stored entry as it travels down the chain
	typedef struct packed {
		logic              valid;
		logic [DATA_W-1:0] key;
		logic [DATA_W-1:0] value;
	} entry_t;

	// Update command broadcast to every cell
	typedef struct packed {
		logic hit;     // move the matching entry to the head
		logic insert;  // push a new entry in at the head
		logic evict;   // drop the last valid entry while inserting
	} lkvc_ctl_t;

endpackage

FILE: rtl/core/lkvc_cell.sv
module lkvc_cell (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         lookup_en,
	input  logic [lkvc_pkg::DATA_W-1:0]  lookup_key,
	input  lkvc_pkg::lkvc_ctl_t          ctl,
	input  lkvc_pkg::entry_t             prev_entry,
	input  logic                         match_or_in,
	input  logic [lkvc_pkg::DATA_W-1:0]  hit_value_in,
	output lkvc_pkg::entry_t             entry,
	output logic                         match,
	output logic                         match_or_out,
	output logic [lkvc_pkg::DATA_W-1:0]  hit_value_out
);
	import lkvc_pkg::*;

	logic              valid_q;
	logic [DATA_W-1:0] key_q;
	logic [DATA_W-1:0] value_q;
	logic              match_s1;
	logic              take;
	logic              valid_d;

	// Collect matches and the matched value from the tail towards the head
	assign match_or_out  = match_s1 | match_or_in;
	assign hit_value_out = (match_s1 ? value_q : '0) | hit_value_in;

	// Shift in from the neighbour: on a hit only cells up to the matching one move
	always_comb begin
		take = (ctl.hit && match_or_out) || ctl.insert;
		if (ctl.insert) begin
			// the last valid entry falls off when its successor is empty
			valid_d = prev_entry.valid & ~(ctl.evict & ~valid_q);
		end else begin
			valid_d = prev_entry.valid;
		end
	end

	// Valid mark and registered key compare
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= 1'b0;
			match_s1 <= 1'b0;
		end else begin
			if (take) begin
				valid_q <= valid_d;
			end
			if (lookup_en) begin
				match_s1 <= valid_q && (key_q == lookup_key);
			end
		end
	end

	// Payload follows the valid mark
	always_ff @(posedge clk) begin
		if (take) begin
			key_q   <= prev_entry.key;
			value_q <= prev_entry.value;
		end
	end

	assign entry.valid = valid_q;
	assign entry.key   = key_q;
	assign entry.value = value_q;
	assign match       = match_s1;

endmodule

FILE: rtl/core/lru_key_value_cache.sv
// Fully associative key/value cache with least-recently-used replacement, built as a
// chain of entry cells ordered by recency: the head cell holds the most recent entry.
// An item is taken when start is high and busy is low. In a lookup step every cell
// compares its key with the item key and registers the match; in the move step after
// it the chain moves on a hit or a stored put (the hit entry, or the new entry, goes
// to the head and the cells in front of it shift one place down). busy is high in the
// move step, so no item is taken then. The result appears on found and read_value for
// exactly one cycle, marked by done, in the cycle after the move step; it cannot be
// held off, so the receiver must take it then. capacity may only be written while no
// item is in flight. After reset the cache is empty and ready at once.
module lru_key_value_cache #(
	parameter int unsigned ENTRIES = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         capacity_wr_en,
	input  logic [4:0]                   capacity_wr_data,
	input  logic                         start,
	output logic                         busy,
	input  logic                         operation,
	input  logic signed [31:0]           key,
	input  logic signed [31:0]           value,
	output logic                         done,
	output logic                         found,
	output logic signed [31:0]           read_value
);
	import lkvc_pkg::*;

	`include "lru_key_value_cache_defines.svh"

	localparam int unsigned OCC_W = $clog2(ENTRIES + 1);
	localparam int unsigned CAP_W = (OCC_W > 5) ? OCC_W : 5;
	localparam logic [4:0]  CAP_RESET = 5'd16;

	logic [4:0]        capacity_q;
	logic [OCC_W-1:0]  occ_q;
	logic              pend_s1;
	op_t               op_s1;
	logic [DATA_W-1:0] key_s1;
	logic [DATA_W-1:0] value_s1;
	logic              done_q;
	logic              found_q;
	logic [DATA_W-1:0] read_value_q;

	logic              accept;
	logic [CAP_W-1:0]  cap_ext;
	logic [CAP_W-1:0]  eff_cap;
	logic              hit_any;
	lkvc_ctl_t         ctl;
	entry_t            head_entry;
	logic [DATA_W-1:0] read_value_d;

	entry_t            cell_entry [ENTRIES];
	entry_t            prev_entry [ENTRIES];
	logic [ENTRIES:0]  match_or;
	logic [DATA_W-1:0] hit_value [ENTRIES+1];
	logic [ENTRIES-1:0] match_vec;

	assign accept = start && !busy;
	assign busy   = pend_s1;

	// Capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
		end else if (capacity_wr_en) begin
			capacity_q <= capacity_wr_data;
		end
	end

	// Limit capacity to the number of cells
	always_comb begin
		cap_ext = CAP_W'(capacity_q);
		eff_cap = (cap_ext > CAP_W'(ENTRIES)) ? CAP_W'(ENTRIES) : cap_ext;
	end

	// Lookup stage: hold the item while the cells compare
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s1 <= 1'b0;
		end else begin
			pend_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1    <= op_t'(operation);
			key_s1   <= key;
			value_s1 <= value;
		end
	end

	// Decide how the chain moves
	assign hit_any = match_or[0];

	always_comb begin
		ctl.hit    = pend_s1 && hit_any;
		ctl.insert = pend_s1 && !hit_any && (op_s1 == OP_PUT) && (eff_cap != '0);
		ctl.evict  = ctl.insert && (CAP_W'(occ_q) >= eff_cap);
	end

	// Entry entering the head cell
	always_comb begin
		head_entry.valid = 1'b1;
		head_entry.key   = key_s1;
		if (op_s1 == OP_PUT) begin
			head_entry.value = value_s1;
		end else begin
			head_entry.value = hit_value[0];
		end
	end

	// Occupancy: grow on an insert that evicts nothing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else if (ctl.insert && !ctl.evict) begin
			occ_q <= occ_q + OCC_W'(1);
		end
	end

	// Row of cells, head first
	assign match_or[ENTRIES]  = 1'b0;
	assign hit_value[ENTRIES] = '0;

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		if (i == 0) begin : g_head
			assign prev_entry[i] = head_entry;
		end else begin : g_body
			assign prev_entry[i] = cell_entry[i-1];
		end

		lkvc_cell u_cell (
			.clk           (clk),
			.arst_n        (arst_n),
			.lookup_en     (accept),
			.lookup_key    (key),
			.ctl           (ctl),
			.prev_entry    (prev_entry[i]),
			.match_or_in   (match_or[i+1]),
			.hit_value_in  (hit_value[i+1]),
			.entry         (cell_entry[i]),
			.match         (match_vec[i]),
			.match_or_out  (match_or[i]),
			.hit_value_out (hit_value[i])
		);
	end

	// Form the result
	always_comb begin
		unique case (op_s1)
			OP_PUT:  read_value_d = PUT_VALUE;
			OP_GET:  read_value_d = hit_any ? hit_value[0] : MISS_VALUE;
			default: read_value_d = MISS_VALUE;
		endcase
	end

	// Output register: one-cycle strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= pend_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (pend_s1) begin
			found_q      <= hit_any;
			read_value_q <= read_value_d;
		end
	end

	assign done       = done_q;
	assign found      = found_q;
	assign read_value = read_value_q;

	`LKVC_ASSERT_IMP(a_accept_result, start && !busy, ##2 done)
	`LKVC_ASSERT_IMP(a_done_follows_work, done, $past(busy))
	`LKVC_ASSERT_IMP(a_match_unique, pend_s1, $onehot0(match_vec))
	`LKVC_ASSERT_IMP(a_occ_bound, 1'b1, occ_q <= OCC_W'(ENTRIES))

endmodule

FILE: bench/lru_cache_checker.sv
module lru_cache_checker #(
	parameter int unsigned ENTRIES = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               capacity_wr_en,
	input  logic [4:0]                         capacity_wr_data,
	input  logic                               start,
	input  logic                               busy,
	input  logic                               operation,
	input  logic signed [lkvc_pkg::DATA_W-1:0] key,
	input  logic signed [lkvc_pkg::DATA_W-1:0] value,
	input  logic                               done,
	input  logic                               found,
	input  logic signed [lkvc_pkg::DATA_W-1:0] read_value,
	output int                                 pending,
	output int                                 mismatches
);
	import lkvc_pkg::*;

	typedef struct {
		logic              found;
		logic [DATA_W-1:0] read_value;
	} reply_t;

	// Replies still owed by the cache, oldest first
	reply_t expected_replies[$];

	// Shadow copy of the cache contents and its capacity register
	logic [DATA_W-1:0] slot_key [ENTRIES];
	logic [DATA_W-1:0] slot_val [ENTRIES];
	bit                slot_used [ENTRIES];
	int unsigned       slot_age [ENTRIES];
	int unsigned       fill;
	logic [4:0]        capacity_reg;

	task automatic report_mismatch(input string msg);
		$display("%0t: %s", $time, msg);
		mismatches++;
	endtask

	// Make a slot the most recent; entries newer than it age by one
	function automatic void make_newest(input int s);
		int unsigned rank;
		rank = slot_age[s];
		for (int i = 0; i < ENTRIES; i++)
			if (slot_used[i] && slot_age[i] < rank)
				slot_age[i]++;
		slot_age[s] = 0;
	endfunction

	// Drop the least recent entry, the later slot winning a tie
	function automatic void drop_least_recent();
		int victim;
		victim = -1;
		for (int i = 0; i < ENTRIES; i++)
			if (slot_used[i] && (victim < 0 || slot_age[i] >= slot_age[victim]))
				victim = i;
		if (victim >= 0) begin
			slot_used[victim] = 1'b0;
			slot_age[victim] = 0;
			if (fill > 0)
				fill--;
		end
	endfunction

	// Apply one get or put to the shadow cache and return the reply it owes
	function automatic reply_t cache_access(input op_t op, input logic [DATA_W-1:0] k,
			input logic [DATA_W-1:0] v);
		reply_t      r;
		int          hit;
		int unsigned limit;
		hit = -1;
		limit = (capacity_reg > ENTRIES) ? ENTRIES : capacity_reg;
		for (int i = 0; i < ENTRIES; i++)
			if (slot_used[i] && slot_key[i] == k)
				hit = i;

		if (op == OP_GET) begin
			if (hit >= 0) begin
				make_newest(hit);
				r.found = 1'b1;
				r.read_value = slot_val[hit];
			end else begin
				r.found = 1'b0;
				r.read_value = MISS_VALUE;
			end
			return r;
		end

		r.read_value = PUT_VALUE;
		if (hit >= 0) begin
			slot_val[hit] = v;
			make_newest(hit);
			r.found = 1'b1;
			return r;
		end
		r.found = 1'b0;
		// zero capacity: the new entry would be its own victim
		if (limit == 0)
			return r;
		if (fill >= limit)
			drop_least_recent();
		for (int i = 0; i < ENTRIES; i++) begin
			if (!slot_used[i]) begin
				for (int j = 0; j < ENTRIES; j++)
					if (slot_used[j])
						slot_age[j]++;
				slot_used[i] = 1'b1;
				slot_key[i] = k;
				slot_val[i] = v;
				slot_age[i] = 0;
				fill++;
				break;
			end
		end
		return r;
	endfunction

	// Retire results, then predict newly accepted transactions and register writes
	always @(posedge clk or negedge arst_n) begin : watch
		reply_t want;
		if (!arst_n) begin
			for (int i = 0; i < ENTRIES; i++) begin
				slot_used[i] = 1'b0;
				slot_age[i] = 0;
			end
			fill = 0;
			capacity_reg = 5'd16;
			expected_replies.delete();
		end else begin
			if (done) begin
				if (expected_replies.size() == 0) begin
					report_mismatch($sformatf("result with nothing pending: found=%0b read_value=%0d",
						found, read_value));
				end else begin
					want = expected_replies.pop_front();
					if (found !== want.found)
						report_mismatch($sformatf("found: got %0b, want %0b", found, want.found));
					if (read_value !== want.read_value)
						report_mismatch($sformatf("read_value: got %0d, want %0d", read_value,
							$signed(want.read_value)));
				end
			end
			if (start && !busy)
				expected_replies.push_back(cache_access(op_t'(operation), key, value));
			if (capacity_wr_en)
				capacity_reg = capacity_wr_data;
		end
		pending = expected_replies.size();
	end

endmodule

FILE: bench/testbench.sv
module testbench;
	import lkvc_pkg::*;

	localparam int STALL_LIMIT   = 1000;
	localparam int RANDOM_PHASES = 9;
	localparam int PHASE_ITEMS   = 170;

	logic              clk              = 1'b0;
	logic              arst_n           = 1'b0;
	logic              capacity_wr_en   = 1'b0;
	logic [4:0]        capacity_wr_data = '0;
	logic              start            = 1'b0;
	logic              operation        = 1'b0;
	logic [DATA_W-1:0] key              = '0;
	logic [DATA_W-1:0] value            = '0;
	logic              busy;
	logic              done;
	logic              found;
	logic signed [DATA_W-1:0] read_value;
	int                pending;
	int                mismatches;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	lru_key_value_cache dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.capacity_wr_en   (capacity_wr_en),
		.capacity_wr_data (capacity_wr_data),
		.start            (start),
		.busy             (busy),
		.operation        (operation),
		.key              (key),
		.value            (value),
		.done             (done),
		.found            (found),
		.read_value       (read_value)
	);

	lru_cache_checker cache_check (
		.clk              (clk),
		.arst_n           (arst_n),
		.capacity_wr_en   (capacity_wr_en),
		.capacity_wr_data (capacity_wr_data),
		.start            (start),
		.busy             (busy),
		.operation        (operation),
		.key              (key),
		.value            (value),
		.done             (done),
		.found            (found),
		.read_value       (read_value),
		.pending          (pending),
		.mismatches       (mismatches)
	);

	// Present one transaction and hold it until the cache takes it
	task automatic issue(input op_t op, input logic [DATA_W-1:0] k, input logic [DATA_W-1:0] v);
		@(negedge clk);
		start <= 1'b1;
		operation <= op;
		key <= k;
		value <= v;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	task automatic hold_off(input int cycles);
		@(negedge clk);
		start <= 1'b0;
		repeat (cycles - 1)
			@(negedge clk);
	endtask

	// Stop sending until every owed result has come back
	task automatic drain();
		@(negedge clk);
		start <= 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	task automatic set_capacity(input logic [4:0] cap);
		drain();
		capacity_wr_en <= 1'b1;
		capacity_wr_data <= cap;
		@(negedge clk);
		capacity_wr_en <= 1'b0;
	endtask

	// Random gets and puts over a key pool a little larger than the capacity
	task automatic run_phase(input logic [4:0] cap, input int items, input bit allow_idle);
		logic [DATA_W-1:0] pool [24];
		int                pool_size;
		int unsigned       eff;
		logic [DATA_W-1:0] k;
		op_t               op;
		set_capacity(cap);
		eff = (cap > 16) ? 16 : cap;
		pool_size = eff + 1 + $urandom_range(0, 4);
		for (int i = 0; i < pool_size; i++)
			pool[i] = $urandom;
		case ($urandom_range(0, 3))
			0: pool[0] = 32'h8000_0000;
			1: pool[0] = 32'h7FFF_FFFF;
			2: pool[0] = 32'hFFFF_FFFF;
			default: pool[0] = 32'h0000_0000;
		endcase
		for (int n = 0; n < items; n++) begin
			op = $urandom_range(0, 1) ? OP_PUT : OP_GET;
			k = ($urandom_range(0, 9) == 0) ? $urandom : pool[$urandom_range(0, pool_size - 1)];
			issue(op, k, $urandom);
			if (allow_idle && $urandom_range(0, 5) == 0)
				hold_off($urandom_range(1, 12));
			if (allow_idle && $urandom_range(0, 199) == 0)
				drain();
		end
	endtask

	// End the run if nothing moves on either channel for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (start && !busy) || done)
				quiet = 0;
			else
				quiet++;
		end
		$display("Mismatches found");
		$finish;
	end

	initial begin : stimulus
		logic [4:0] caps [RANDOM_PHASES];
		caps = '{5'd1, 5'd4, 5'd16, 5'd0, 5'd31, 5'd2, 5'd0, 5'd9, 5'd16};
		caps[6] = $urandom_range(0, 31);

		repeat (11)
			@(negedge clk);
		arst_n <= 1'b1;

		// Empty cache, extreme keys and values, update of a stored key
		issue(OP_GET, 32'h0000_0000, 32'h0000_0000);
		issue(OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
		issue(OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
		issue(OP_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		issue(OP_PUT, 32'h0000_0000, 32'h0000_0000);
		issue(OP_GET, 32'hFFFF_FFFF, 32'h0000_0000);
		issue(OP_GET, 32'h8000_0000, 32'hFFFF_FFFF);
		issue(OP_PUT, 32'h7FFF_FFFF, 32'h1234_5678);
		issue(OP_GET, 32'h7FFF_FFFF, 32'h0000_0000);
		issue(OP_GET, 32'h0000_0001, 32'h0000_0000);

		// Capacity lowered below occupancy: each new key evicts just one entry
		set_capacity(5'd2);
		issue(OP_PUT, 32'h0000_0010, 32'hA5A5_A5A5);
		issue(OP_PUT, 32'h0000_0020, 32'h5A5A_5A5A);
		issue(OP_GET, 32'h0000_0000, 32'h0000_0000);
		issue(OP_GET, 32'h0000_0010, 32'h0000_0000);
		issue(OP_GET, 32'h8000_0000, 32'h0000_0000);
		issue(OP_PUT, 32'h0000_0030, 32'h0000_0003);

		// Zero capacity: a new key is not stored, a stored key still updates
		set_capacity(5'd0);
		issue(OP_PUT, 32'h0000_0040, 32'h0000_0004);
		issue(OP_GET, 32'h0000_0040, 32'h0000_0000);
		issue(OP_PUT, 32'h0000_0030, 32'hDEAD_BEEF);
		issue(OP_GET, 32'h0000_0030, 32'h0000_0000);

		// Capacity above the entry count saturates
		set_capacity(5'd31);
		issue(OP_PUT, 32'h0000_0050, 32'h0000_0005);
		issue(OP_GET, 32'h0000_0020, 32'h0000_0000);

		set_capacity(5'd1);
		issue(OP_PUT, 32'h0000_0060, 32'h0000_0006);
		issue(OP_GET, 32'h0000_0060, 32'h0000_0000);

		// Random phases; the last one runs without gaps
		for (int p = 0; p < RANDOM_PHASES; p++)
			run_phase(caps[p], PHASE_ITEMS, p != RANDOM_PHASES - 1);

		drain();
		repeat (8)
			@(negedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/lkvc_pkg.sv
rtl/core/lkvc_cell.sv
rtl/core/lru_key_value_cache.sv
bench/lru_cache_checker.sv
bench/testbench.sv
